// ===== hw/rtl/rectangle_fill_outline_raster_defines.svh =====
// Assertion macros for the rectangle rasterizer RTL.
// Included by files that carry concurrent checks; needs nothing else.
`ifndef RECTANGLE_FILL_OUTLINE_RASTER_DEFINES_SVH
`define RECTANGLE_FILL_OUTLINE_RASTER_DEFINES_SVH

// same-cycle implication, checks off while reset is high
`define RFOR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checks off while reset is high
`define RFOR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/rfor_pkg.sv =====
// Shared types and constants for the rectangle rasterizer.
// Used by rfor_cover and rectangle_fill_outline_raster; no dependencies.
`default_nettype none

package rfor_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;
   localparam int DEF_FRAC_BITS  = 8;

   // configuration register indexes
   localparam logic [1:0] REG_CANVAS_WIDTH    = 2'd0;
   localparam logic [1:0] REG_CANVAS_HEIGHT   = 2'd1;
   localparam logic [1:0] REG_BACKGROUND_CODE = 2'd2;

   localparam logic [7:0] BACKGROUND_RESET = 8'd32;

   typedef enum logic [1:0] {
      KIND_CLEAR = 2'd0,
      KIND_DRAW  = 2'd1,
      KIND_READ  = 2'd2,
      KIND_NOP   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_ERROR   = 2'd1,
      STATUS_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SWEEP,
      S_READ,
      S_READ_OUT
   } state_type;

   // rectangle geometry in fixed point, right/bottom already summed
   typedef struct packed {
      logic        filled;
      logic [20:0] left;
      logic [20:0] top;
      logic [21:0] right;
      logic [21:0] bottom;
   } rect_type;

endpackage

`default_nettype wire

// ===== hw/rtl/rfor_cover.sv =====
// Pixel coverage unit: decides whether the pixel at (col, row) takes the paint code.
// Depends on rfor_pkg (rect_type, default fraction width).
`default_nettype none

module rfor_cover #(
   parameter int FRAC_BITS = rfor_pkg::DEF_FRAC_BITS
) (
   input  logic [8:0]        col,
   input  logic [8:0]        row,
   input  rfor_pkg::rect_type rect,
   output logic              paint
);

   localparam int CMP_W = (((9 + FRAC_BITS) > 22) ? (9 + FRAC_BITS) : 22) + 2;
   localparam logic signed [CMP_W-1:0] ONE = CMP_W'(1) << FRAC_BITS;

   logic signed [CMP_W-1:0] px;
   logic signed [CMP_W-1:0] py;
   logic signed [CMP_W-1:0] left_x;
   logic signed [CMP_W-1:0] right_x;
   logic signed [CMP_W-1:0] top_y;
   logic signed [CMP_W-1:0] bottom_y;
   logic signed [CMP_W-1:0] d_left;
   logic signed [CMP_W-1:0] d_right;
   logic signed [CMP_W-1:0] d_top;
   logic signed [CMP_W-1:0] d_bottom;
   logic                    in_x;
   logic                    in_y;
   logic                    edge_x;
   logic                    edge_y;

   assign px       = CMP_W'(col) << FRAC_BITS;
   assign py       = CMP_W'(row) << FRAC_BITS;
   assign left_x   = {{(CMP_W-21){rect.left[20]}}, rect.left};
   assign right_x  = {{(CMP_W-22){rect.right[21]}}, rect.right};
   assign top_y    = {{(CMP_W-21){rect.top[20]}}, rect.top};
   assign bottom_y = {{(CMP_W-22){rect.bottom[21]}}, rect.bottom};

   assign d_left   = px - left_x;
   assign d_right  = right_x - px;
   assign d_top    = py - top_y;
   assign d_bottom = bottom_y - py;

   // inside when both distances are non-negative
   assign in_x   = !d_left[CMP_W-1] && !d_right[CMP_W-1];
   assign in_y   = !d_top[CMP_W-1] && !d_bottom[CMP_W-1];
   assign edge_x = (d_left < ONE) || (d_right < ONE);
   assign edge_y = (d_top < ONE) || (d_bottom < ONE);

   assign paint = in_x && in_y && (rect.filled || edge_x || edge_y);

endmodule

`default_nettype wire

// ===== hw/rtl/rectangle_fill_outline_raster.sv =====
// Rectangle rasterizer on a character canvas; top level. Uses rfor_pkg, rfor_cover
// and the assertion macros in rectangle_fill_outline_raster_defines.svh.
//
// Command channel: a transaction is taken at a clock edge with start high and busy
// low. req_kind selects clear, draw or read; the other req_ fields carry the
// rectangle or the read position. Every transaction gives one result on rsp_status
// and rsp_pixel_code, shown for one cycle with rsp_valid; the receiver cannot stall.
// How each result is produced after the accepting edge:
//   clear and accepted draw: a sweep of all W*H pixels (W, H the canvas size), one pixel swept
//     per cycle through the single canvas memory write port and the coverage unit, then the result register;
//   read inside the canvas: read address register, registered memory read, then the result register;
//   rejected draw, read with error or outside the canvas, unknown kind: the result register alone.
// busy stays high for the whole sweep or read; a new command can be taken in the
// cycle in which the previous result is shown.
// csr_ writes set canvas width, height and background code; width and height are
// saturated to 1..MAX. Write them only while busy is low.
// Reset clears the error flag and restores the register defaults; the canvas
// contents are undefined until the first clear.
`default_nettype none

`include "rectangle_fill_outline_raster_defines.svh"

module rectangle_fill_outline_raster #(
   parameter int MAX_WIDTH  = rfor_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = rfor_pkg::DEF_MAX_HEIGHT,
   parameter int FRAC_BITS  = rfor_pkg::DEF_FRAC_BITS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic        req_filled,
   input  logic [20:0] req_rect_left,
   input  logic [20:0] req_rect_top,
   input  logic [19:0] req_rect_width,
   input  logic [19:0] req_rect_height,
   input  logic [7:0]  req_paint_code,
   input  logic [7:0]  req_read_column,
   input  logic [7:0]  req_read_row,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_pixel_code,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_wdata
);

   localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [13:0] MAX_W_DIM = 14'(MAX_WIDTH);
   localparam logic [13:0] MAX_H_DIM = 14'(MAX_HEIGHT);
   localparam logic [8:0]  WIDTH_RESET  = 9'((MAX_WIDTH < 256) ? MAX_WIDTH : 256);
   localparam logic [8:0]  HEIGHT_RESET = 9'((MAX_HEIGHT < 256) ? MAX_HEIGHT : 256);
   localparam logic [ADDR_W-1:0] ROW_STEP = ADDR_W'(MAX_WIDTH);

   function automatic logic [8:0] clamp_dim(input logic [8:0] v, input logic [13:0] max_dim);
      logic [8:0] r;
      if (v == 9'd0) begin
         r = 9'd1;
      end else if ({5'b0, v} > max_dim) begin
         r = max_dim[8:0];
      end else begin
         r = v;
      end
      return r;
   endfunction

   rfor_pkg::state_type state_ff, state_in;

   logic [8:0]        width_ff;
   logic [8:0]        height_ff;
   logic [7:0]        background_ff;
   logic              error_ff, error_in;
   logic [8:0]        col_ff, col_in;
   logic [8:0]        row_ff, row_in;
   logic [ADDR_W-1:0] row_base_ff, row_base_in;
   logic              sweep_clear_ff, sweep_clear_in;
   logic [7:0]        code_ff, code_in;
   rfor_pkg::rect_type rect_ff, rect_in;
   logic [ADDR_W-1:0] rd_addr_ff, rd_addr_in;
   logic [7:0]        rd_data_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_status_ff, rsp_status_in;
   logic [7:0]        rsp_pixel_ff, rsp_pixel_in;

   logic              accept;
   logic              last_col;
   logic              last_row;
   logic              paint;
   logic              zero_size;
   logic              read_outside;
   logic              mem_we;
   logic [ADDR_W-1:0] mem_waddr;
   rfor_pkg::kind_type kind;

   logic [7:0] canvas_mem [DEPTH];

   assign kind         = rfor_pkg::kind_type'(req_kind);
   assign busy         = (state_ff != rfor_pkg::S_IDLE);
   assign accept       = start && !busy;
   assign last_col     = (col_ff == width_ff - 9'd1);
   assign last_row     = (row_ff == height_ff - 9'd1);
   assign zero_size    = (req_rect_width == 20'd0) || (req_rect_height == 20'd0);
   assign read_outside = ({1'b0, req_read_column} >= width_ff) ||
                         ({1'b0, req_read_row} >= height_ff);
   assign mem_waddr    = row_base_ff + ADDR_W'(col_ff);

   rfor_cover #(
      .FRAC_BITS(FRAC_BITS)
   ) u_cover (
      .col   (col_ff),
      .row   (row_ff),
      .rect  (rect_ff),
      .paint (paint)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rfor_pkg::S_IDLE: begin
            if (accept) begin
               case (kind)
                  rfor_pkg::KIND_CLEAR: begin
                     state_in = rfor_pkg::S_SWEEP;
                  end
                  rfor_pkg::KIND_DRAW: begin
                     if (!error_ff && !zero_size) begin
                        state_in = rfor_pkg::S_SWEEP;
                     end
                  end
                  rfor_pkg::KIND_READ: begin
                     if (!error_ff && !read_outside) begin
                        state_in = rfor_pkg::S_READ;
                     end
                  end
                  default: begin
                     state_in = rfor_pkg::S_IDLE;
                  end
               endcase
            end
         end
         rfor_pkg::S_SWEEP: begin
            if (last_col && last_row) begin
               state_in = rfor_pkg::S_IDLE;
            end
         end
         rfor_pkg::S_READ: begin
            state_in = rfor_pkg::S_READ_OUT;
         end
         rfor_pkg::S_READ_OUT: begin
            state_in = rfor_pkg::S_IDLE;
         end
         default: begin
            state_in = rfor_pkg::S_IDLE;
         end
      endcase
   end

   // datapath and result controls
   always_comb begin
      error_in       = error_ff;
      col_in         = col_ff;
      row_in         = row_ff;
      row_base_in    = row_base_ff;
      sweep_clear_in = sweep_clear_ff;
      code_in        = code_ff;
      rect_in        = rect_ff;
      rd_addr_in     = rd_addr_ff;
      rsp_valid_in   = 1'b0;
      rsp_status_in  = rfor_pkg::STATUS_OK;
      rsp_pixel_in   = 8'd0;
      mem_we         = 1'b0;
      case (state_ff)
         rfor_pkg::S_IDLE: begin
            if (accept) begin
               col_in         = 9'd0;
               row_in         = 9'd0;
               row_base_in    = '0;
               sweep_clear_in = (kind == rfor_pkg::KIND_CLEAR);
               code_in        = (kind == rfor_pkg::KIND_CLEAR) ? background_ff : req_paint_code;
               rect_in.filled = req_filled;
               rect_in.left   = req_rect_left;
               rect_in.top    = req_rect_top;
               rect_in.right  = {req_rect_left[20], req_rect_left} + {2'b00, req_rect_width};
               rect_in.bottom = {req_rect_top[20], req_rect_top} + {2'b00, req_rect_height};
               rd_addr_in     = ADDR_W'(ADDR_W'(req_read_row) * ROW_STEP) +
                                ADDR_W'(req_read_column);
               case (kind)
                  rfor_pkg::KIND_CLEAR: begin
                     rsp_valid_in = 1'b0;
                  end
                  rfor_pkg::KIND_DRAW: begin
                     if (error_ff || zero_size) begin
                        error_in      = 1'b1;
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rfor_pkg::STATUS_ERROR;
                     end
                  end
                  rfor_pkg::KIND_READ: begin
                     if (error_ff) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rfor_pkg::STATUS_ERROR;
                     end else if (read_outside) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = rfor_pkg::STATUS_OUTSIDE;
                     end
                  end
                  default: begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = error_ff ? rfor_pkg::STATUS_ERROR : rfor_pkg::STATUS_OK;
                  end
               endcase
            end
         end
         rfor_pkg::S_SWEEP: begin
            mem_we = sweep_clear_ff || paint;
            if (last_col) begin
               col_in      = 9'd0;
               row_in      = row_ff + 9'd1;
               row_base_in = row_base_ff + ROW_STEP;
               if (last_row) begin
                  rsp_valid_in = 1'b1;
                  if (sweep_clear_ff) begin
                     error_in = 1'b0;
                  end
               end
            end else begin
               col_in = col_ff + 9'd1;
            end
         end
         rfor_pkg::S_READ_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_pixel_in = rd_data_ff;
         end
         default: begin
            rsp_valid_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= rfor_pkg::S_IDLE;
         error_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         width_ff      <= WIDTH_RESET;
         height_ff     <= HEIGHT_RESET;
         background_ff <= rfor_pkg::BACKGROUND_RESET;
      end else begin
         state_ff     <= state_in;
         error_ff     <= error_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            case (csr_index)
               rfor_pkg::REG_CANVAS_WIDTH: begin
                  width_ff <= clamp_dim(csr_wdata, MAX_W_DIM);
               end
               rfor_pkg::REG_CANVAS_HEIGHT: begin
                  height_ff <= clamp_dim(csr_wdata, MAX_H_DIM);
               end
               rfor_pkg::REG_BACKGROUND_CODE: begin
                  background_ff <= csr_wdata[7:0];
               end
               default: begin
                  background_ff <= background_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      col_ff         <= col_in;
      row_ff         <= row_in;
      row_base_ff    <= row_base_in;
      sweep_clear_ff <= sweep_clear_in;
      code_ff        <= code_in;
      rect_ff        <= rect_in;
      rd_addr_ff     <= rd_addr_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_pixel_ff   <= rsp_pixel_in;
   end

   // canvas memory: one write port for the sweep, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         canvas_mem[mem_waddr] <= code_ff;
      end
      if (state_ff == rfor_pkg::S_READ) begin
         rd_data_ff <= canvas_mem[rd_addr_ff];
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pixel_code = rsp_pixel_ff;

   `RFOR_ASSERT_NEXT(a_accept_progress, clock, reset, accept, busy || rsp_valid, "accepted transaction neither busy nor answered")
   `RFOR_ASSERT_SAME(a_sweep_in_canvas, clock, reset, state_ff == rfor_pkg::S_SWEEP, (col_ff < width_ff) && (row_ff < height_ff), "sweep position outside canvas")
   `RFOR_ASSERT_SAME(a_error_from_draw, clock, reset, $rose(error_ff), $past(accept && (req_kind == rfor_pkg::KIND_DRAW)), "error flag set without a draw")
   `RFOR_ASSERT_SAME(a_pixel_zero_not_ok, clock, reset, rsp_valid && (rsp_status != rfor_pkg::STATUS_OK), rsp_pixel_code == 8'd0, "nonzero pixel on a failed result")

endmodule

`default_nettype wire
